// File: design/fixed_block_free_list_allocator_unit_defines.svh
// Assertion macros used by the checker file of the block pool allocator.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FBFLA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FBFLA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fbfla_pkg.sv
// Shared constants, codes and types of the block pool allocator.
`default_nettype none
package fbfla_pkg;

    localparam int NUM_BLOCKS      = 256;
    localparam int CAPACITY        = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
    localparam int LINK_AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IDX_W           = 8;
    localparam int CNT_W           = 9;
    localparam int BSIZE_W         = 16;
    localparam int BYTES_W         = 24;
    localparam int TALLY_W         = 32;
    localparam int CFG_AW          = 2;
    localparam int CFG_DW          = 16;

    localparam logic [CNT_W-1:0] DEFAULT_INITIAL = 9'd64;
    localparam logic [CNT_W-1:0] CAP_CNT         = CNT_W'(CAPACITY);

    // opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_INITIAL = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_BSIZE   = 2'd2;

    typedef struct packed {
        logic               we;
        logic [LINK_AW-1:0] addr;
        logic [IDX_W-1:0]   wdata;
    } t_ram_req;

    // result word, status in the lowest bits
    typedef struct packed {
        logic [TALLY_W-1:0] frees_done;
        logic [TALLY_W-1:0] allocs_done;
        logic [BYTES_W-1:0] byte_used;
        logic [BYTES_W-1:0] byte_total;
        logic [CNT_W-1:0]   free_left;
        logic [CNT_W-1:0]   used_count;
        logic [CNT_W-1:0]   total_count;
        logic [IDX_W-1:0]   alloc_index;
        logic [1:0]         status;
    } t_result;

endpackage
`default_nettype wire

// File: design/fixed_block_free_list_allocator_unit.sv
// Top level of the fixed-size block pool allocator with a LIFO free list.
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  opcode, block_index
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  status and pool statistics
//  cfg       in   i_cfg_we                         i_cfg_addr, i_cfg_wdata
//
// Allocate, free and ignored opcodes step through S_EXEC (uses the link-memory read),
// S_MUL0, S_MUL1 and S_MUL2 (two passes through the shared multiplier) and S_OUT,
// which writes the result; s_axis is ready again in the cycle the result appears.
// Reset pool adds a rebuild walk over the effective initial blocks,
// one link-memory write per cycle.
// After i_rst_n the same walk runs (64 blocks by default) before s_axis is ready.
// A finished result waits in the output register; the next word is taken
// meanwhile, and only the final write to the output stalls on m_axis.
`default_nettype none
module fixed_block_free_list_allocator_unit
    import fbfla_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [CFG_DW-1:0]  i_cfg_wdata,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // [1:0] opcode, [9:2] block_index, [15:10] zero
    input  wire logic [15:0]        i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    // [1:0] status, [9:2] alloc_index, [18:10] total_count, [27:19] used_count,
    // [36:28] free_left, [60:37] byte_total, [84:61] byte_used,
    // [116:85] allocs_done, [148:117] frees_done, [151:149] zero
    output logic [151:0]            o_m_axis_tdata
);

    t_ram_req             w_ram_req;
    logic [IDX_W-1:0]     w_ram_rdata;
    logic [CNT_W-1:0]     w_mul_count;
    logic [BSIZE_W-1:0]   w_mul_bsize;
    logic [BYTES_W-1:0]   w_mul_bytes;
    t_result              w_res;

    fbfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_s_axis_tvalid),
        .i_req_op    (i_s_axis_tdata[1:0]),
        .i_req_idx   (i_s_axis_tdata[9:2]),
        .o_req_ready (o_s_axis_tready),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (w_res),
        .o_ram_req   (w_ram_req),
        .i_ram_rdata (w_ram_rdata),
        .o_mul_count (w_mul_count),
        .o_mul_bsize (w_mul_bsize),
        .i_mul_bytes (w_mul_bytes)
    );

    fbfla_link_ram u_link_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

    fbfla_mul_unit u_mul (
        .i_clk   (i_clk),
        .i_count (w_mul_count),
        .i_bsize (w_mul_bsize),
        .o_bytes (w_mul_bytes)
    );

    assign o_m_axis_tdata = {3'b000, w_res};

endmodule
`default_nettype wire

// File: design/fbfla_link_ram.sv
// Link memory of the free list: one port, registered read data.
`default_nettype none
module fbfla_link_ram
    import fbfla_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_ram_req         i_req,
    output logic [IDX_W-1:0]      o_rdata
);

    logic [IDX_W-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end

endmodule
`default_nettype wire

// File: design/fbfla_mul_unit.sv
// Shared block-count by block-size multiplier, registered product.
`default_nettype none
module fbfla_mul_unit
    import fbfla_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [CNT_W-1:0]   i_count,
    input  wire logic [BSIZE_W-1:0] i_bsize,
    output logic [BYTES_W-1:0]      o_bytes
);

    logic [CNT_W+BSIZE_W-1:0] w_full;

    assign w_full = (CNT_W+BSIZE_W)'(i_count) * (CNT_W+BSIZE_W)'(i_bsize);

    always_ff @(posedge i_clk) begin
        o_bytes <= w_full[BYTES_W-1:0];
    end

endmodule
`default_nettype wire

// File: design/fbfla_ctrl.sv
// Sequencer: list rebuild walk, allocate/free update, statistics and result register.
`default_nettype none
module fbfla_ctrl
    import fbfla_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [CFG_DW-1:0]  i_cfg_wdata,
    // request
    input  wire logic               i_req_valid,
    input  wire logic [1:0]         i_req_op,
    input  wire logic [IDX_W-1:0]   i_req_idx,
    output logic                    o_req_ready,
    // result
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output t_result                 o_res,
    // link memory
    output t_ram_req                o_ram_req,
    input  wire logic [IDX_W-1:0]   i_ram_rdata,
    // multiplier
    output logic [CNT_W-1:0]        o_mul_count,
    output logic [BSIZE_W-1:0]      o_mul_bsize,
    input  wire logic [BYTES_W-1:0] i_mul_bytes
);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_EXEC, S_MUL0, S_MUL1, S_MUL2, S_OUT
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_pos;
    logic                 r_pend;
    logic [CNT_W-1:0]     r_initial;
    logic [CNT_W-1:0]     r_max;
    logic [BSIZE_W-1:0]   r_bsize;
    logic [IDX_W-1:0]     r_head;
    logic                 r_empty;
    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_used;
    logic [TALLY_W-1:0]   r_allocs;
    logic [TALLY_W-1:0]   r_frees;
    logic [1:0]           r_op;
    logic [IDX_W-1:0]     r_idx;
    logic [1:0]           r_status;
    logic [IDX_W-1:0]     r_given;
    logic [BYTES_W-1:0]   r_tbytes;
    logic [BYTES_W-1:0]   r_ubytes;

    logic [CNT_W-1:0]     w_init_n;
    logic [CNT_W-1:0]     w_cap;
    logic [CNT_W-1:0]     w_pos_m1;
    logic [CNT_W-1:0]     w_used_p1;
    logic                 w_walk;
    logic                 w_free_ok;

    // effective initial count (0 = default) and cap (0 = none), clipped to capacity
    always_comb begin
        if (r_initial == '0) begin
            w_init_n = DEFAULT_INITIAL;
        end else if (r_initial > CAP_CNT) begin
            w_init_n = CAP_CNT;
        end else begin
            w_init_n = r_initial;
        end
        if (r_max != '0 && r_max < CAP_CNT) begin
            w_cap = r_max;
        end else begin
            w_cap = CAP_CNT;
        end
    end

    assign w_pos_m1  = r_pos - 9'd1;
    assign w_used_p1 = r_used + 9'd1;
    assign w_walk    = (r_pos < w_init_n);
    assign w_free_ok = ({1'b0, r_idx} < r_total) && (r_used != '0);

    // memory port: rebuild writes, head read on accept, link write on free
    always_comb begin
        o_ram_req.we    = 1'b0;
        o_ram_req.addr  = r_head[LINK_AW-1:0];
        o_ram_req.wdata = r_head;
        if (r_state == S_INIT && w_walk) begin
            o_ram_req.we    = 1'b1;
            o_ram_req.addr  = r_pos[LINK_AW-1:0];
            o_ram_req.wdata = w_pos_m1[IDX_W-1:0];
        end else if (r_state == S_EXEC && r_op == OP_FREE && w_free_ok) begin
            o_ram_req.we    = 1'b1;
            o_ram_req.addr  = r_idx[LINK_AW-1:0];
        end
    end

    assign o_mul_count = (r_state == S_MUL0) ? r_total : r_used;
    assign o_mul_bsize = r_bsize;
    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_pos       <= 9'd1;
            r_pend      <= 1'b0;
            r_initial   <= DEFAULT_INITIAL;
            r_max       <= '0;
            r_bsize     <= 16'd64;
            r_head      <= '0;
            r_empty     <= 1'b0;
            r_total     <= '0;
            r_used      <= '0;
            r_allocs    <= '0;
            r_frees     <= '0;
            o_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_INITIAL: r_initial <= i_cfg_wdata[CNT_W-1:0];
                    CFG_MAX:     r_max     <= i_cfg_wdata[CNT_W-1:0];
                    CFG_BSIZE:   r_bsize   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // S_OUT handles the output register itself
            if (o_res_valid && i_res_ready && r_state != S_OUT) begin
                o_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    // entry i links to i-1, one entry per cycle
                    if (w_walk) begin
                        r_pos <= r_pos + 9'd1;
                    end else begin
                        r_head  <= w_init_n[IDX_W-1:0] - 8'd1;
                        r_empty <= 1'b0;
                        r_total <= w_init_n;
                        r_used  <= '0;
                        r_pend  <= 1'b0;
                        r_state <= r_pend ? S_MUL0 : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_op    <= i_req_op;
                        r_idx   <= i_req_idx;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_op)
                        OP_ALLOC: begin
                            r_state <= S_MUL0;
                            if (!r_empty) begin
                                r_status <= ST_OK;
                                r_given  <= r_head;
                                r_used   <= w_used_p1;
                                r_allocs <= r_allocs + 32'd1;
                                r_empty  <= (w_used_p1 >= r_total);
                                if (w_used_p1 < r_total) begin
                                    r_head <= i_ram_rdata;
                                end
                            end else if (r_total >= w_cap) begin
                                r_status <= ST_EXHAUSTED;
                                r_given  <= '0;
                            end else begin
                                // grow by one fresh block
                                r_status <= ST_OK;
                                r_given  <= r_total[IDX_W-1:0];
                                r_total  <= r_total + 9'd1;
                                r_used   <= w_used_p1;
                                r_allocs <= r_allocs + 32'd1;
                                r_empty  <= 1'b1;
                            end
                        end
                        OP_FREE: begin
                            r_state <= S_MUL0;
                            r_given <= '0;
                            if (w_free_ok) begin
                                r_status <= ST_OK;
                                r_head   <= r_idx;
                                r_empty  <= 1'b0;
                                r_used   <= r_used - 9'd1;
                                r_frees  <= r_frees + 32'd1;
                            end else begin
                                r_status <= ST_INVALID;
                            end
                        end
                        OP_RESET: begin
                            r_status <= ST_OK;
                            r_given  <= '0;
                            r_pos    <= 9'd1;
                            r_pend   <= 1'b1;
                            r_state  <= S_INIT;
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_given  <= '0;
                            r_state  <= S_MUL0;
                        end
                    endcase
                end
                S_MUL0: r_state <= S_MUL1;
                S_MUL1: begin
                    r_tbytes <= i_mul_bytes;
                    r_state  <= S_MUL2;
                end
                S_MUL2: begin
                    r_ubytes <= i_mul_bytes;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!o_res_valid || i_res_ready) begin
                        o_res_valid       <= 1'b1;
                        o_res.status      <= r_status;
                        o_res.alloc_index <= r_given;
                        o_res.total_count <= r_total;
                        o_res.used_count  <= r_used;
                        o_res.free_left   <= r_total - r_used;
                        o_res.byte_total  <= r_tbytes;
                        o_res.byte_used   <= r_ubytes;
                        o_res.allocs_done <= r_allocs;
                        o_res.frees_done  <= r_frees;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: design/fbfla_checker.sv
// Port-level checker for the block pool allocator, bound to the top level.
`default_nettype none
`include "fixed_block_free_list_allocator_unit_defines.svh"
module fbfla_checker
    import fbfla_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [CFG_DW-1:0]  i_cfg_wdata,
    input  wire logic               i_s_axis_tvalid,
    input  wire logic               o_s_axis_tready,
    input  wire logic [15:0]        i_s_axis_tdata,
    input  wire logic               o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    input  wire logic [151:0]       o_m_axis_tdata
);

    `FBFLA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result word dropped or changed while stalled")

    `FBFLA_ASSERT_IMP(a_free_left, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[36:28] == 9'(o_m_axis_tdata[18:10] - o_m_axis_tdata[27:19]), "free_left differs from total minus used")

    `FBFLA_ASSERT_IMP(a_used_le_total, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[27:19] <= o_m_axis_tdata[18:10] && o_m_axis_tdata[1:0] != 2'd3, "used above total or bad status")

    `FBFLA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input taken again while busy")

endmodule

bind fixed_block_free_list_allocator_unit fbfla_checker u_fbfla_checker (.*);
`default_nettype wire
